### sv/isort_pkg.sv
// Shared types and constants for the insertion sorter.
package isort_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ELEMS_DEF = 16;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctrl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                     valid;
    logic                     gt;
    logic signed [DATA_W-1:0] data;
  } cell_out_t;

endpackage

### sv/isort_cell.sv
// One slot of the sorted chain: holds an entry, inserts or shifts down.
module isort_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  isort_pkg::cell_ctrl_t             ctrl,
  input  logic signed [isort_pkg::DATA_W-1:0] ins_value,
  input  isort_pkg::cell_out_t              left,
  input  isort_pkg::cell_out_t              right,
  output isort_pkg::cell_out_t              cell_q
);
  import isort_pkg::*;

  logic                     valid;
  logic signed [DATA_W-1:0] data;
  logic                     gt;
  logic                     take;

  // Greater entries move up; the first empty slot takes part in the insert too.
  always_comb begin
    gt   = valid && (data > ins_value);
    take = gt || (!valid && left.valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.drain) begin
      valid <= right.valid;
    end else if (ctrl.insert && take) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.drain) begin
      data <= right.data;
    end else if (ctrl.insert && take) begin
      data <= left.gt ? left.data : ins_value;
    end
  end

  assign cell_q.valid = valid;
  assign cell_q.gt    = gt;
  assign cell_q.data  = data;

endmodule

### sv/insertion_sorter_top.sv
// Top level of the insertion sorter: cell chain and drain control.
//
//   channel | handshake                 | payload
//   --------+---------------------------+----------------------------------
//   input   | start & !busy             | value, last_in
//   result  | result_strobe (no stall)  | sorted_value, last_out, overflowed
//
// An item that is not last is inserted as it is accepted; all cells compare against
// it in parallel, so a new item can be taken every cycle while busy is low.
// An item marked last is inserted, then the chain shifts down one entry per
// cycle, giving n results, with busy high while they go out.
// Items arriving with the chain full are dropped and the list is flagged.
// Reset empties the chain; results cannot be stalled.
module insertion_sorter_top #(
  parameter int MAX_ELEMS = isort_pkg::MAX_ELEMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [isort_pkg::DATA_W-1:0] value,
  input  logic                                last_in,
  output logic                                result_strobe,
  output logic signed [isort_pkg::DATA_W-1:0] sorted_value,
  output logic                                last_out,
  output logic                                overflowed
);
  import isort_pkg::*;

  state_t     state;
  state_t     state_next;
  cell_ctrl_t ctrl;
  cell_out_t  cells [MAX_ELEMS];
  logic       accept;
  logic       full;
  logic       final_out;
  logic       overflow_flag;

  assign accept    = start && !busy;
  assign full      = cells[MAX_ELEMS-1].valid;
  assign final_out = !cells[1].valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && last_in) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (final_out) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy          = 1'b0;
    result_strobe = 1'b0;
    ctrl.insert   = 1'b0;
    ctrl.drain    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ctrl.insert = accept && !full;
      end
      ST_DRAIN: begin
        busy          = 1'b1;
        result_strobe = 1'b1;
        ctrl.drain    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Set on a dropped item, clear once the list has gone out.
  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_flag <= 1'b0;
    end else if (accept && full) begin
      overflow_flag <= 1'b1;
    end else if (ctrl.drain && final_out) begin
      overflow_flag <= 1'b0;
    end
  end

  for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
    cell_out_t left;
    cell_out_t right;

    if (i == 0) begin : g_head
      assign left = '{valid: 1'b1, gt: 1'b0, data: '0};
    end else begin : g_body
      assign left = cells[i-1];
    end

    if (i == MAX_ELEMS - 1) begin : g_tail
      assign right = '{valid: 1'b0, gt: 1'b0, data: '0};
    end else begin : g_next
      assign right = cells[i+1];
    end

    isort_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .ins_value (value),
      .left      (left),
      .right     (right),
      .cell_q    (cells[i])
    );
  end

  assign sorted_value = cells[0].data;
  assign last_out     = final_out;
  assign overflowed   = overflow_flag;

endmodule
